@@ rtl/tdf_pkg.sv @@
package tdf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int SPEED_W   = 31;
    localparam int STEP_W    = 17;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DIV_N_W   = 50;
    localparam int DIV_D_W   = 33;
    localparam int SQRT_W    = 32;
    localparam int ROOT_W    = 16;
    localparam int K_W       = 17;
    localparam int U_W       = 48;
    localparam int UC_W      = FRAC_BITS + 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 1'b1;

    localparam logic signed [DATA_W-1:0] S32MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] S32MIN = 32'sh8000_0000;

    function automatic logic signed [PROD_W-1:0] ext32(input logic signed [DATA_W-1:0] x);
        return {{(PROD_W-DATA_W){x[DATA_W-1]}}, x};
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
        logic [PROD_W-DATA_W:0] top;
        top = x[PROD_W-1:DATA_W-1];
        if ((&top) || (~|top)) begin
            return x[DATA_W-1:0];
        end else if (x[PROD_W-1]) begin
            return S32MIN;
        end else begin
            return S32MAX;
        end
    endfunction

endpackage

@@ rtl/tracking_differentiator_fhan_top.sv @@
// Discrete tracking differentiator (fhan) in signed Q16.16. Each transfer on
// the input stream carries one target sample; the block returns the tracked
// value and rate as they stood before the update, then runs the fhan step on
// one shared 33x33 multiplier, a 50-step restoring divider and a bit-serial
// square root. The outer zone takes longer than the linear zone, and its
// time also depends on the count of k corrections; the divider makes one
// pass for 1/(h*h*r) and one for the outer-zone quotient, and the first
// is skipped when h*h*r rounds to zero. The input is not ready
// while a step runs. The configuration channel, speed_factor (index 0) and
// sample_step (index 1), is ready only while the block is idle.
module tracking_differentiator_fhan_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [tdf_pkg::DATA_W-1:0]         i_s_axis_tdata,   // target_sample
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [2*tdf_pkg::DATA_W-1:0]       o_m_axis_tdata,   // tracked_rate (upper), tracked_value (lower)
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tdf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tdf_pkg::SPEED_W-1:0]        i_cfg_data
);
    import tdf_pkg::*;

    typedef enum logic [18:0] {
        ST_IDLE   = 19'd1 << 0,
        ST_HX2    = 19'd1 << 1,
        ST_HH     = 19'd1 << 2,
        ST_HHR    = 19'd1 << 3,
        ST_DSTART = 19'd1 << 4,
        ST_DWAIT  = 19'd1 << 5,
        ST_PROD   = 19'd1 << 6,
        ST_ZONE   = 19'd1 << 7,
        ST_ULIN   = 19'd1 << 8,
        ST_SQRT   = 19'd1 << 9,
        ST_KCHK   = 19'd1 << 10,
        ST_KADJ   = 19'd1 << 11,
        ST_KHX    = 19'd1 << 12,
        ST_QSTART = 19'd1 << 13,
        ST_QWAIT  = 19'd1 << 14,
        ST_QD     = 19'd1 << 15,
        ST_UOUT   = 19'd1 << 16,
        ST_A      = 19'd1 << 17,
        ST_UPD    = 19'd1 << 18
    } t_state;

    localparam logic [PROD_W-1:0] ZONE_LIM  = PROD_W'(1) << (2 * FRAC_BITS);
    localparam logic [PROD_W-1:0] CEIL_ADD  = (PROD_W'(1) << (2 * FRAC_BITS - 1)) - 1'b1;
    localparam logic signed [U_W-1:0] ONE_U = U_W'(1) << FRAC_BITS;
    localparam logic signed [U_W-1:0] NEG_ONE_U = -(U_W'(1) << FRAC_BITS);

    t_state r_state;
    t_state n_state;

    logic signed [DATA_W-1:0]  r_x1;
    logic signed [DATA_W-1:0]  r_x2;
    logic [SPEED_W-1:0]        r_speed;
    logic [STEP_W-1:0]         r_step;
    logic signed [DATA_W-1:0]  r_v;
    logic signed [DATA_W-1:0]  r_e;
    logic signed [DATA_W-1:0]  r_hx2;
    logic signed [DATA_W-1:0]  r_y;
    logic [SPEED_W-1:0]        r_d;
    logic [SQRT_W-1:0]         r_q2;
    logic [K_W-1:0]            r_k;
    logic [1:0]                r_iter;
    logic                      r_qneg;
    logic signed [DATA_W-1:0]  r_q;
    logic signed [UC_W-1:0]    r_u;
    logic                      r_out_valid;
    logic [2*DATA_W-1:0]       r_out_data;
    logic                      r_ha_phase;

    logic signed [MUL_W-1:0]   s_mul_a;
    logic signed [MUL_W-1:0]   s_mul_b;
    logic signed [PROD_W-1:0]  s_prod;
    logic signed [PROD_W-1:0]  s_psh;
    logic [PROD_W-1:0]         s_prod_u;
    logic [DIV_D_W-1:0]        s_hhr;
    logic [SPEED_W-1:0]        s_absy;
    logic signed [DATA_W-1:0]  s_ylin;
    logic [PROD_W-1:0]         s_q2_full;
    logic signed [PROD_W-1:0]  s_num;
    logic signed [PROD_W-1:0]  s_num_mag;
    logic signed [PROD_W-1:0]  s_quo_s;
    logic signed [U_W-1:0]     s_t1;
    logic signed [U_W-1:0]     s_u_out;
    logic signed [U_W-1:0]     s_u_lin;
    logic signed [U_W-1:0]     s_u;
    logic signed [UC_W-1:0]    s_u_clamp;
    logic [K_W-1:0]            s_k_dec;
    logic signed [MUL_W-1:0]   s_ha_a;
    logic signed [MUL_W-1:0]   s_ha_b;

    logic                      s_in_acc;
    logic                      s_div_start;
    logic [DIV_N_W-1:0]        s_div_n;
    logic [DIV_D_W-1:0]        s_div_d;
    logic                      s_div_done;
    logic [DIV_N_W-1:0]        s_div_q;
    logic                      s_sqrt_start;
    logic                      s_sqrt_done;
    logic [ROOT_W-1:0]         s_root;

    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign s_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = (r_state == ST_IDLE);

    tdf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (s_mul_a),
        .i_b   (s_mul_b),
        .o_p   (s_prod)
    );

    tdf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_div_start),
        .i_dividend (s_div_n),
        .i_divisor  (s_div_d),
        .o_done     (s_div_done),
        .o_quotient (s_div_q)
    );

    tdf_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_sqrt_start),
        .i_radicand (s_q2_full[2*FRAC_BITS-1 +: SQRT_W]),
        .o_done     (s_sqrt_done),
        .o_root     (s_root)
    );

    // shared datapath terms
    always_comb begin
        s_psh     = s_prod >>> FRAC_BITS;
        s_prod_u  = $unsigned(s_prod);
        s_hhr     = s_prod_u[FRAC_BITS +: DIV_D_W];
        s_absy    = (r_y == S32MIN) ? S32MAX[SPEED_W-1:0]
                  : (r_y[DATA_W-1] ? SPEED_W'(-r_y) : r_y[SPEED_W-1:0]);
        s_ylin    = sat32(ext32(r_y) + ext32(r_hx2));
        s_q2_full = s_prod_u + CEIL_ADD;
        s_k_dec   = r_k - 1'b1;
        s_num     = s_prod + ext32(r_e);
        s_num_mag = s_num[PROD_W-1] ? -s_num : s_num;
        s_quo_s   = $signed({{(PROD_W-DIV_N_W){1'b0}}, s_div_q});
        s_t1      = ONE_U - ($signed({{(U_W-K_W){1'b0}}, r_k}) <<< (FRAC_BITS - 1));
        if (r_y[DATA_W-1]) begin
            s_t1 = -s_t1;
        end
        s_u_out   = s_t1 - s_psh[U_W-1:0];
        s_u_lin   = -s_psh[U_W-1:0];
        s_u       = (r_state == ST_ULIN) ? s_u_lin : s_u_out;
        if (s_u > ONE_U) begin
            s_u_clamp = ONE_U[UC_W-1:0];
        end else if (s_u < NEG_ONE_U) begin
            s_u_clamp = NEG_ONE_U[UC_W-1:0];
        end else begin
            s_u_clamp = s_u[UC_W-1:0];
        end
    end

    // the acceleration term a = r*u >> F sits in s_psh during the first cycle of ST_UPD
    assign s_ha_a = $signed({{(MUL_W-STEP_W){1'b0}}, r_step});
    assign s_ha_b = $signed({s_psh[DATA_W-1], s_psh[DATA_W-1:0]});

    // operand select for the shared multiplier
    always_comb begin
        s_mul_a = '0;
        s_mul_b = '0;
        unique case (r_state)
            ST_HX2: begin
                s_mul_a = $signed({{(MUL_W-STEP_W){1'b0}}, r_step});
                s_mul_b = $signed({r_x2[DATA_W-1], r_x2});
            end
            ST_HH: begin
                s_mul_a = $signed({{(MUL_W-STEP_W){1'b0}}, r_step});
                s_mul_b = $signed({{(MUL_W-STEP_W){1'b0}}, r_step});
            end
            ST_HHR: begin
                s_mul_a = $signed({{(MUL_W-STEP_W-1){1'b0}}, s_prod_u[FRAC_BITS +: STEP_W+1]});
                s_mul_b = $signed({{(MUL_W-SPEED_W){1'b0}}, r_speed});
            end
            ST_PROD: begin
                s_mul_a = $signed({{(MUL_W-SPEED_W){1'b0}}, s_absy});
                s_mul_b = $signed({{(MUL_W-SPEED_W){1'b0}}, r_d});
            end
            ST_ZONE: begin
                s_mul_a = $signed({s_ylin[DATA_W-1], s_ylin});
                s_mul_b = $signed({{(MUL_W-SPEED_W){1'b0}}, r_d});
            end
            ST_KCHK: begin
                s_mul_a = $signed({{(MUL_W-K_W){1'b0}}, r_k});
                s_mul_b = $signed({{(MUL_W-K_W){1'b0}}, s_k_dec});
            end
            ST_KHX: begin
                s_mul_a = $signed({{(MUL_W-K_W){1'b0}}, r_k});
                s_mul_b = $signed({r_hx2[DATA_W-1], r_hx2});
            end
            ST_QD: begin
                s_mul_a = $signed({r_q[DATA_W-1], r_q});
                s_mul_b = $signed({{(MUL_W-SPEED_W){1'b0}}, r_d});
            end
            ST_A: begin
                s_mul_a = $signed({{(MUL_W-SPEED_W){1'b0}}, r_speed});
                s_mul_b = $signed({{(MUL_W-UC_W){r_u[UC_W-1]}}, r_u});
            end
            ST_UPD: begin
                s_mul_a = s_ha_a;
                s_mul_b = s_ha_b;
            end
            default: begin
                s_mul_a = '0;
                s_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        s_div_start  = 1'b0;
        s_div_n      = '0;
        s_div_d      = '0;
        s_sqrt_start = 1'b0;
        n_state      = r_state;
        unique case (r_state)
            ST_IDLE:   if (s_in_acc) n_state = ST_HX2;
            ST_HX2:    n_state = ST_HH;
            ST_HH:     n_state = ST_HHR;
            ST_HHR:    n_state = ST_DSTART;
            ST_DSTART: begin
                if (s_hhr == '0) begin
                    n_state = ST_PROD;
                end else begin
                    s_div_start = 1'b1;
                    s_div_n     = DIV_N_W'(1) << (2 * FRAC_BITS);
                    s_div_d     = s_hhr;
                    n_state     = ST_DWAIT;
                end
            end
            ST_DWAIT:  if (s_div_done) n_state = ST_PROD;
            ST_PROD:   n_state = ST_ZONE;
            ST_ZONE: begin
                if (s_prod_u <= ZONE_LIM) begin
                    n_state = ST_ULIN;
                end else begin
                    s_sqrt_start = 1'b1;
                    n_state      = ST_SQRT;
                end
            end
            ST_ULIN:   n_state = ST_A;
            ST_SQRT:   if (s_sqrt_done) n_state = ST_KCHK;
            ST_KCHK:   n_state = ST_KADJ;
            ST_KADJ: begin
                if ((s_prod_u < {{(PROD_W-SQRT_W){1'b0}}, r_q2}) && (r_iter != 2'd3)) begin
                    n_state = ST_KCHK;
                end else begin
                    n_state = ST_KHX;
                end
            end
            ST_KHX:    n_state = ST_QSTART;
            ST_QSTART: begin
                s_div_start = 1'b1;
                s_div_n     = s_num_mag[DIV_N_W-1:0];
                s_div_d     = {{(DIV_D_W-K_W){1'b0}}, s_k_dec};
                n_state     = ST_QWAIT;
            end
            ST_QWAIT:  if (s_div_done) n_state = ST_QD;
            ST_QD:     n_state = ST_UOUT;
            ST_UOUT:   n_state = ST_A;
            ST_A:      n_state = ST_UPD;
            ST_UPD:    if (r_ha_phase) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_x1        <= '0;
            r_x2        <= '0;
            r_speed     <= SPEED_W'(1) << FRAC_BITS;
            r_step      <= STEP_W'(1) << FRAC_BITS;
            r_ha_phase  <= 1'b0;
            r_iter      <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_SPEED: r_speed <= i_cfg_data;
                    CFG_STEP:  r_step  <= i_cfg_data[STEP_W-1:0];
                    default:   ;
                endcase
            end

            if (s_in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_in_acc) begin
                        r_v        <= $signed(i_s_axis_tdata);
                        r_out_data <= {r_x2, r_x1};
                    end
                end
                ST_HX2:    r_e   <= sat32(ext32(r_x1) - ext32(r_v));
                ST_HH:     r_hx2 <= sat32(s_psh);
                ST_HHR:    r_y   <= sat32(ext32(r_e) + ext32(r_hx2));
                ST_DSTART: if (s_hhr == '0) r_d <= S32MAX[SPEED_W-1:0];
                ST_DWAIT: begin
                    if (s_div_done) begin
                        r_d <= (s_div_q[DIV_N_W-1:SPEED_W] != '0) ? S32MAX[SPEED_W-1:0]
                                                                   : s_div_q[SPEED_W-1:0];
                    end
                end
                ST_ZONE:   r_q2 <= s_q2_full[2*FRAC_BITS-1 +: SQRT_W];
                ST_ULIN:   r_u  <= s_u_clamp;
                ST_SQRT: begin
                    if (s_sqrt_done) begin
                        r_k    <= (s_root < ROOT_W'(2)) ? K_W'(2) : {{(K_W-ROOT_W){1'b0}}, s_root};
                        r_iter <= '0;
                    end
                end
                ST_KADJ: begin
                    if ((s_prod_u < {{(PROD_W-SQRT_W){1'b0}}, r_q2}) && (r_iter != 2'd3)) begin
                        r_k    <= r_k + 1'b1;
                        r_iter <= r_iter + 1'b1;
                    end
                end
                ST_QSTART: r_qneg <= s_num[PROD_W-1];
                ST_QWAIT: begin
                    if (s_div_done) begin
                        r_q <= sat32(r_qneg ? -s_quo_s : s_quo_s);
                    end
                end
                ST_UOUT:   r_u <= s_u_clamp;
                ST_A:      r_ha_phase <= 1'b0;
                ST_UPD: begin
                    // first cycle: a = r*u >> F is ready, h*a issues; second: integrate
                    if (!r_ha_phase) begin
                        r_ha_phase <= 1'b1;
                    end else begin
                        r_ha_phase <= 1'b0;
                        r_x1 <= sat32(ext32(r_x1) + ext32(r_hx2));
                        r_x2 <= sat32(ext32(r_x2) + (s_prod >>> FRAC_BITS));
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_s_axis_tready)
        else $error("input ready while a step runs");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in_acc |=> o_m_axis_tvalid)
        else $error("accepted item produced no result");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_div_done |-> (r_state == ST_DWAIT || r_state == ST_QWAIT))
        else $error("divider finished outside a wait state");

    a_u_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_A) |-> (r_u <= $signed(ONE_U[UC_W-1:0])
                               && r_u >= $signed(NEG_ONE_U[UC_W-1:0])))
        else $error("control left its clamp range");
`endif

endmodule

@@ rtl/tdf_mul.sv @@
module tdf_mul (
    input  logic                               i_clk,
    input  logic signed [tdf_pkg::MUL_W-1:0]   i_a,
    input  logic signed [tdf_pkg::MUL_W-1:0]   i_b,
    output logic signed [tdf_pkg::PROD_W-1:0]  o_p
);
    import tdf_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    function automatic logic signed [PROD_W-1:0] ext_mul(
        input logic signed [MUL_W-1:0] a,
        input logic signed [MUL_W-1:0] b
    );
        logic signed [PROD_W-1:0] wa;
        logic signed [PROD_W-1:0] wb;
        wa = {{(PROD_W-MUL_W){a[MUL_W-1]}}, a};
        wb = {{(PROD_W-MUL_W){b[MUL_W-1]}}, b};
        return wa * wb;
    endfunction

    always_ff @(posedge i_clk) begin
        r_p <= ext_mul(i_a, i_b);
    end

    assign o_p = r_p;

endmodule

@@ rtl/tdf_div.sv @@
module tdf_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [tdf_pkg::DIV_N_W-1:0]      i_dividend,
    input  logic [tdf_pkg::DIV_D_W-1:0]      i_divisor,
    output logic                             o_done,
    output logic [tdf_pkg::DIV_N_W-1:0]      o_quotient
);
    import tdf_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [DIV_D_W-1:0]  r_rem;
    logic [DIV_D_W-1:0]  r_div;
    logic [DIV_N_W-1:0]  r_quo;

    logic [DIV_D_W:0]    s_trial;
    logic [DIV_D_W:0]    s_diff;
    logic                s_fit;

    assign s_trial = {r_rem, r_quo[DIV_N_W-1]};
    assign s_diff  = s_trial - {1'b0, r_div};
    assign s_fit   = (s_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_N_W - 1);
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                // one quotient bit per cycle, restoring
                r_rem <= s_fit ? s_diff[DIV_D_W-1:0] : s_trial[DIV_D_W-1:0];
                r_quo <= {r_quo[DIV_N_W-2:0], s_fit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/tdf_sqrt.sv @@
module tdf_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tdf_pkg::SQRT_W-1:0]    i_radicand,
    output logic                          o_done,
    output logic [tdf_pkg::ROOT_W-1:0]    o_root
);
    import tdf_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [SQRT_W-1:0]  r_x;
    logic [SQRT_W-1:0]  r_res;
    logic [SQRT_W-1:0]  r_bit;
    logic [SQRT_W-1:0]  s_sum;

    assign s_sum = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_x    <= i_radicand;
                r_res  <= '0;
                r_bit  <= SQRT_W'(1) << (SQRT_W - 2);
            end else if (r_busy) begin
                // one root digit per cycle
                if (r_x >= s_sum) begin
                    r_x   <= r_x - s_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule
